>>> src/hsfrf_pkg.sv
// ----------------------------------------------------------------------------
// hsfrf_pkg
// shared constants and helper functions for the haptic report framer
// ----------------------------------------------------------------------------
package hsfrf_pkg;

  // input commands
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // report byte positions
  localparam logic [7:0] POS_ID        = 8'd0;
  localparam logic [7:0] POS_SEQ       = 8'd1;
  localparam logic [7:0] POS_CFG_HDR   = 8'd2;
  localparam logic [7:0] POS_CFG_LEN   = 8'd3;
  localparam logic [7:0] POS_CFG_FE    = 8'd4;
  localparam logic [7:0] POS_CFG_FF    = 8'd9;
  localparam logic [7:0] POS_FRAME     = 8'd10;
  localparam logic [7:0] POS_AUD_HDR   = 8'd11;
  localparam logic [7:0] POS_AUD_LEN   = 8'd12;
  localparam logic [7:0] POS_AUD_FIRST = 8'd13;
  localparam logic [7:0] POS_AUD_LAST  = 8'd76;
  localparam logic [7:0] POS_CRC       = 8'd137;
  localparam logic [7:0] POS_LAST      = 8'd140;

  // report byte values
  localparam logic [7:0] REPORT_ID  = 8'h32;
  localparam logic [7:0] CFG_HDR    = 8'h45;  // (0x11 << 2) | 1
  localparam logic [7:0] CFG_LEN    = 8'd7;
  localparam logic [7:0] CFG_FE     = 8'hFE;
  localparam logic [7:0] CFG_FF     = 8'hFF;
  localparam logic [7:0] AUD_HDR    = 8'h49;  // (0x12 << 2) | 1
  localparam logic [7:0] AUD_LEN    = 8'd64;
  localparam logic [7:0] SILENCE    = 8'h80;

  // crc-32, reflected ieee
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // valid byte counts of a beat
  localparam logic [2:0] VB_FULL = 3'd4;
  localparam logic [2:0] VB_LAST = 3'd1;

  // one byte through the crc, bit at a time
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'h0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // fixed report content; audio positions give the silence value
  function automatic logic [7:0] fixed_byte(input logic [7:0] pos,
                                            input logic [3:0] seq,
                                            input logic [7:0] frame);
    logic [7:0] v;
    v = 8'h00;
    if (pos >= POS_AUD_FIRST && pos <= POS_AUD_LAST) begin
      v = SILENCE;
    end else begin
      case (pos)
        POS_ID:      v = REPORT_ID;
        POS_SEQ:     v = {seq, 4'h0};
        POS_CFG_HDR: v = CFG_HDR;
        POS_CFG_LEN: v = CFG_LEN;
        POS_CFG_FE:  v = CFG_FE;
        POS_CFG_FF:  v = CFG_FF;
        POS_FRAME:   v = frame;
        POS_AUD_HDR: v = AUD_HDR;
        POS_AUD_LEN: v = AUD_LEN;
        default:     v = 8'h00;
      endcase
    end
    return v;
  endfunction

endpackage

>>> src/hsfrf_sample_mem.sv
// ----------------------------------------------------------------------------
// hsfrf_sample_mem
// sample store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module hsfrf_sample_mem #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/hsfrf_fifo_ctrl.sv
// ----------------------------------------------------------------------------
// hsfrf_fifo_ctrl
// ring pointers and fill count; oldest sample dropped on a full push
// ----------------------------------------------------------------------------
module hsfrf_fifo_ctrl #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13,
  parameter int CNT_W  = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              pop,
  output logic [ADDR_W-1:0] wr_ptr,
  output logic [ADDR_W-1:0] rd_ptr,
  output logic              not_empty
);

  localparam logic [ADDR_W-1:0] PTR_TOP = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(DEPTH);

  logic [ADDR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ADDR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r,   fill_nxt;
  logic [ADDR_W-1:0] wr_ptr_inc, rd_ptr_inc;

  // wrapping increments
  assign wr_ptr_inc = (wr_ptr_r == PTR_TOP) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc = (rd_ptr_r == PTR_TOP) ? '0 : rd_ptr_r + 1'b1;

  // pointer and count update; push and pop never coincide
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    priority if (push) begin
      wr_ptr_nxt = wr_ptr_inc;
      if (fill_r < CNT_MAX) begin
        fill_nxt = fill_r + 1'b1;
      end else begin
        rd_ptr_nxt = rd_ptr_inc;
      end
    end else if (pop) begin
      rd_ptr_nxt = rd_ptr_inc;
      fill_nxt   = fill_r - 1'b1;
    end else begin
      fill_nxt = fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign wr_ptr    = wr_ptr_r;
  assign rd_ptr    = rd_ptr_r;
  assign not_empty = (fill_r != '0);

endmodule

>>> src/hsfrf_framer.sv
// ----------------------------------------------------------------------------
// hsfrf_framer
// report sequencer: byte issue stage, byte/crc/packing stage, output register
// ----------------------------------------------------------------------------
module hsfrf_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick,
  output logic        busy,
  input  logic        not_empty,
  output logic        pop,
  input  logic [7:0]  rd_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last
);

  import hsfrf_pkg::*;

  // persistent counters
  logic [3:0]  seq_r;
  logic [7:0]  frame_r;
  // report being built
  logic [3:0]  rep_seq_r;
  logic [7:0]  rep_frame_r;
  // issue stage
  logic        active_r;
  logic [7:0]  idx_r;
  // byte stage
  logic        b_valid_r;
  logic [7:0]  b_idx_r;
  logic        b_mem_r;
  logic [7:0]  b_byte_r;
  logic [31:0] crc_r;
  logic [23:0] acc_r;
  // output register
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_vb_r;
  logic        out_last_r;

  logic        stall;
  logic        is_audio;
  logic [7:0]  issue_byte;
  logic [31:0] crc_final;
  logic [7:0]  crc_off;
  logic [7:0]  byte_val;
  logic [31:0] word_nxt;
  logic        emit;
  logic        b_last;

  // everything waits while a finished beat sits untaken
  assign stall = out_valid_r && !out_ready;

  // issue stage: at audio positions a sample is read when one is held, else fixed content
  assign is_audio   = (idx_r >= POS_AUD_FIRST) && (idx_r <= POS_AUD_LAST);
  assign pop        = active_r && !stall && is_audio && not_empty;
  assign issue_byte = fixed_byte(idx_r, rep_seq_r, rep_frame_r);

  // byte stage: pick the byte for this position
  assign crc_final = ~crc_r;
  assign crc_off   = b_idx_r - POS_CRC;
  always_comb begin
    priority if (b_idx_r >= POS_CRC) begin
      unique case (crc_off[1:0])
        2'd0:    byte_val = crc_final[7:0];
        2'd1:    byte_val = crc_final[15:8];
        2'd2:    byte_val = crc_final[23:16];
        default: byte_val = crc_final[31:24];
      endcase
    end else if (b_mem_r) begin
      byte_val = rd_data;
    end else begin
      byte_val = b_byte_r;
    end
  end

  // beat packing, lowest byte first
  assign b_last = (b_idx_r == POS_LAST);
  assign emit   = b_valid_r && !stall && ((b_idx_r[1:0] == 2'd3) || b_last);
  always_comb begin
    unique case (b_idx_r[1:0])
      2'd0:    word_nxt = {24'h0, byte_val};
      2'd1:    word_nxt = {16'h0, byte_val, acc_r[7:0]};
      2'd2:    word_nxt = {8'h0, byte_val, acc_r[15:0]};
      default: word_nxt = {byte_val, acc_r[23:0]};
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      frame_r     <= '0;
      active_r    <= 1'b0;
      idx_r       <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (tick) begin
        active_r    <= 1'b1;
        idx_r       <= '0;
        seq_r       <= seq_r + 1'b1;
        frame_r     <= frame_r + 1'b1;
      end else if (active_r && !stall) begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == POS_LAST) begin
          active_r <= 1'b0;
        end
      end
      if (!stall) begin
        b_valid_r <= active_r;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick) begin
      rep_seq_r   <= seq_r;
      rep_frame_r <= frame_r;
    end
    if (active_r && !stall) begin
      b_idx_r  <= idx_r;
      b_mem_r  <= pop;
      b_byte_r <= issue_byte;
    end
    if (b_valid_r && !stall) begin
      acc_r <= word_nxt[23:0];
      if (b_idx_r == POS_ID) begin
        crc_r <= crc_byte(CRC_INIT, byte_val);
      end else if (b_idx_r < POS_CRC) begin
        crc_r <= crc_byte(crc_r, byte_val);
      end
    end
    if (emit) begin
      out_word_r <= word_nxt;
      out_vb_r   <= b_last ? VB_LAST : VB_FULL;
      out_last_r <= b_last;
    end
  end

  assign busy            = active_r || b_valid_r;
  assign out_valid       = out_valid_r;
  assign out_word        = out_word_r;
  assign out_valid_bytes = out_vb_r;
  assign out_last        = out_last_r;

endmodule

>>> src/haptic_sample_fifo_report_framer_unit.sv
// ----------------------------------------------------------------------------
// haptic_sample_fifo_report_framer_unit
// sample ring fifo with a report framer emitting crc-protected 141-byte reports
// ----------------------------------------------------------------------------
//  channel  dir  ports                                     beat
//  in       in   in_valid/in_ready, in_command, in_sample  one push or tick
//  out      out  out_valid/out_ready, out_word,            up to four report bytes
//                out_valid_bytes, out_last
//
// a push writes the sample to the store at once.
// a tick builds the report one byte a cycle while out is not stalled, reading
// samples from the store through its single read port; an issue stage, one
// byte stage and one output register. in_ready rises in the same cycle as the
// final beat appears on out, so the next item can be taken at the edge that
// takes the final beat. while out holds an untaken beat the report build
// pauses; in_ready is low from tick acceptance until the final byte has been
// packed.
// reset clears pointers, fill count and counters; the store is not cleared.
// ----------------------------------------------------------------------------
module haptic_sample_fifo_report_framer_unit #(
  parameter int FIFO_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_valid_bytes,
  output logic        out_last
);

  import hsfrf_pkg::*;

  localparam int ADDR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  logic              accept;
  logic              push;
  logic              tick;
  logic              busy;
  logic              pop;
  logic              not_empty;
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [7:0]        rd_data;

  // command decode
  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (in_command == CMD_PUSH);
  assign tick     = accept && (in_command == CMD_TICK);

  // pointers and fill count
  hsfrf_fifo_ctrl #(
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_fifo_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .wr_ptr    (wr_ptr),
    .rd_ptr    (rd_ptr),
    .not_empty (not_empty)
  );

  // sample store
  hsfrf_sample_mem #(
    .DEPTH  (FIFO_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_sample_mem (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (wr_ptr),
    .wr_data (in_sample),
    .rd_en   (pop),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  // report builder
  hsfrf_framer u_framer (
    .clk             (clk),
    .rst_n           (rst_n),
    .tick            (tick),
    .busy            (busy),
    .not_empty       (not_empty),
    .pop             (pop),
    .rd_data         (rd_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .out_valid_bytes (out_valid_bytes),
    .out_last        (out_last)
  );

endmodule
